/* hdl/nearest_point_search_2d_assert.svh */
// Assertion macros used by the block's top file.
`ifndef NEAREST_POINT_SEARCH_2D_ASSERT_SVH
`define NEAREST_POINT_SEARCH_2D_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NPS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define NPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/nps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_pkg
// Shared constants, codes and control types of the nearest point search.
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int MAX_REFS_DEF   = 1024;
    localparam int COORD_BITS_DEF = 16;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;

    localparam logic [STATUS_W-1:0] ST_ANSWERED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STORED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic            start;     // item accepted this cycle
        logic [OP_W-1:0] op;        // opcode of the accepted item
        logic            issue;     // read the next table entry
        logic            finish;    // scan drained, latch the answer
        logic            out_load;  // move the result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;      // table holds no point
        logic scan_last;  // entry being issued is the last stored one
        logic busy;       // distance pipeline holds work
    } stat_t;

endpackage

/* hdl/nps_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/nps_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_ctrl
// Controller: accepts items, sequences the table scan and owns the output
// valid flag.
// ----------------------------------------------------------------------------
module nps_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [nps_pkg::OP_W-1:0] in_op,
    output logic                     out_valid,
    input  logic                     out_ready,
    output nps_pkg::cmd_t            cmd,
    input  nps_pkg::stat_t           stat
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd          = '0;
        cmd.start    = accept;
        cmd.op       = in_op;
        cmd.issue    = (state_reg == S_SCAN);
        cmd.finish   = (state_reg == S_DRAIN) && !stat.busy;
        cmd.out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // a query on a non-empty table scans, all else answers at once
                    if (in_op[1] && !stat.empty)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!stat.busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (cmd.out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* hdl/nps_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_dp
// Datapath: point table, fill count, distance pipeline, running minimum and
// output register.
// ----------------------------------------------------------------------------
module nps_dp #(
    parameter int MAX_REFS   = nps_pkg::MAX_REFS_DEF,
    parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF,
    localparam int IDX_W     = $clog2(MAX_REFS),
    localparam int DIST_W    = 2 * COORD_BITS + 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  nps_pkg::cmd_t                cmd,
    output nps_pkg::stat_t               stat,
    input  logic [COORD_BITS-1:0]        point_x,
    input  logic [COORD_BITS-1:0]        point_y,
    output logic [nps_pkg::STATUS_W-1:0] status,
    output logic [IDX_W-1:0]             nearest_index,
    output logic [DIST_W-1:0]            distance_sq
);

    localparam int CB    = COORD_BITS;
    localparam int CNT_W = $clog2(MAX_REFS + 1);
    localparam int SQ_W  = 2 * CB;
    localparam bit SAT_EN = (DIST_W > 64);
    localparam logic [DIST_W-1:0] SAT_VAL = DIST_W'({64{1'b1}});

    // table fill count and query point
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_m1;
    logic [CB-1:0]    qx_reg;
    logic [CB-1:0]    qy_reg;
    logic             full;
    logic             is_load;
    logic             is_clear;
    logic             is_query;
    logic             ram_we;

    // scan pipeline
    logic [IDX_W-1:0] rd_addr_reg;
    logic             v1_reg;
    logic             v2_reg;
    logic             v3_reg;
    logic [IDX_W-1:0] idx1_reg;
    logic [IDX_W-1:0] idx2_reg;
    logic [IDX_W-1:0] idx3_reg;
    logic [2*CB-1:0]  rdata;
    logic [CB:0]      diff_x;
    logic [CB:0]      diff_y;
    logic [CB:0]      abs_x;
    logic [CB:0]      abs_y;
    logic [CB-1:0]    dx_reg;
    logic [CB-1:0]    dy_reg;
    logic [SQ_W-1:0]  sqx_reg;
    logic [SQ_W-1:0]  sqy_reg;
    logic [DIST_W-1:0] sum;
    logic [DIST_W-1:0] dist_sat;

    // running minimum, result and output register
    logic                         have_reg;
    logic [DIST_W-1:0]            best_reg;
    logic [IDX_W-1:0]             best_idx_reg;
    logic [nps_pkg::STATUS_W-1:0] res_status_reg;
    logic [IDX_W-1:0]             res_index_reg;
    logic [DIST_W-1:0]            res_dist_reg;
    logic [nps_pkg::STATUS_W-1:0] out_status_reg;
    logic [IDX_W-1:0]             out_index_reg;
    logic [DIST_W-1:0]            out_dist_reg;

    assign is_query = cmd.op[1];
    assign is_clear = (cmd.op == nps_pkg::OP_CLEAR);
    assign is_load  = (cmd.op == nps_pkg::OP_LOAD);
    assign full     = (count_reg == CNT_W'(MAX_REFS));
    assign count_m1 = count_reg - CNT_W'(1);
    assign ram_we   = cmd.start && is_load && !full;

    assign stat.empty     = (count_reg == '0);
    assign stat.scan_last = (rd_addr_reg == count_m1[IDX_W-1:0]);
    assign stat.busy      = v1_reg || v2_reg || v3_reg;

    nps_ram #(
        .WIDTH (2 * CB),
        .DEPTH (MAX_REFS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({point_y, point_x}),
        .re    (cmd.issue),
        .raddr (rd_addr_reg),
        .rdata (rdata)
    );

    // absolute coordinate differences, one bit wider to hold the sign
    assign diff_x = {qx_reg[CB-1], qx_reg} - {rdata[CB-1], rdata[CB-1:0]};
    assign diff_y = {qy_reg[CB-1], qy_reg} - {rdata[2*CB-1], rdata[2*CB-1:CB]};
    assign abs_x  = diff_x[CB] ? -diff_x : diff_x;
    assign abs_y  = diff_y[CB] ? -diff_y : diff_y;

    assign sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    // clamp to 64 bits on the widest coordinates
    assign dist_sat = (SAT_EN && ((sum >> 64) != '0)) ? SAT_VAL : sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            rd_addr_reg <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            have_reg    <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (cmd.start)
            begin
                if (is_clear)
                begin
                    count_reg <= '0;
                end
                else if (ram_we)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                if (is_query)
                begin
                    rd_addr_reg <= '0;
                    have_reg    <= 1'b0;
                end
            end
            if (cmd.issue)
            begin
                rd_addr_reg <= rd_addr_reg + IDX_W'(1);
            end
            if (v3_reg)
            begin
                have_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            qx_reg        <= point_x;
            qy_reg        <= point_y;
            res_dist_reg  <= '0;
            priority if (is_query)
            begin
                res_status_reg <= nps_pkg::ST_EMPTY;
                res_index_reg  <= '0;
            end
            else if (is_clear)
            begin
                res_status_reg <= nps_pkg::ST_CLEARED;
                res_index_reg  <= '0;
            end
            else if (full)
            begin
                res_status_reg <= nps_pkg::ST_DROPPED;
                res_index_reg  <= '0;
            end
            else
            begin
                res_status_reg <= nps_pkg::ST_STORED;
                res_index_reg  <= count_reg[IDX_W-1:0];
            end
        end
        if (cmd.finish)
        begin
            res_status_reg <= nps_pkg::ST_ANSWERED;
            res_index_reg  <= best_idx_reg;
            res_dist_reg   <= best_reg;
        end

        idx1_reg <= rd_addr_reg;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        dx_reg   <= abs_x[CB-1:0];
        dy_reg   <= abs_y[CB-1:0];
        sqx_reg  <= {{CB{1'b0}}, dx_reg} * {{CB{1'b0}}, dx_reg};
        sqy_reg  <= {{CB{1'b0}}, dy_reg} * {{CB{1'b0}}, dy_reg};

        // first strict minimum wins
        if (v3_reg && (!have_reg || (dist_sat < best_reg)))
        begin
            best_reg     <= dist_sat;
            best_idx_reg <= idx3_reg;
        end

        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
            out_dist_reg   <= res_dist_reg;
        end
    end

    assign status        = out_status_reg;
    assign nearest_index = out_index_reg;
    assign distance_sq   = out_dist_reg;

endmodule

/* hdl/nearest_point_search_2d.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_point_search_2d
// Brute-force 2D nearest point search over a table of signed fixed-point
// reference points, with clear, load and query beats.
// ----------------------------------------------------------------------------
// A clear or load beat, or a query on an empty table, moves its result into
// the output register once that register is free. A query beat on a
// non-empty table reads one stored point per cycle from the single read port
// of the point table, drains the distance pipeline, then moves its answer out
// the same way. Every beat gives one result beat; the next input beat is
// taken as soon as the previous item's result sits in the output register,
// even if that result is not yet taken. The table needs no clearing after
// reset: only entries below the fill count are ever read.
module nearest_point_search_2d #(
    parameter int MAX_REFS   = nps_pkg::MAX_REFS_DEF,
    parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF,
    localparam int IDX_W     = $clog2(MAX_REFS),
    localparam int DIST_W    = 2 * COORD_BITS + 1,
    localparam int IN_W      = ((2 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W     = ((IDX_W + DIST_W + 7) / 8) * 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [IN_W-1:0]              s_axis_tdata,  // point_x, point_y
    input  logic [nps_pkg::OP_W-1:0]     s_axis_tuser,  // opcode
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [OUT_W-1:0]             m_axis_tdata,  // nearest_index, distance_sq
    output logic [nps_pkg::STATUS_W-1:0] m_axis_tuser   // status
);

    nps_pkg::cmd_t     cmd;
    nps_pkg::stat_t    stat;
    logic [IDX_W-1:0]  nearest_index;
    logic [DIST_W-1:0] distance_sq;

    nps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    nps_dp #(
        .MAX_REFS   (MAX_REFS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .point_x       (s_axis_tdata[COORD_BITS-1:0]),
        .point_y       (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .status        (m_axis_tuser),
        .nearest_index (nearest_index),
        .distance_sq   (distance_sq)
    );

    assign m_axis_tdata = OUT_W'({distance_sq, nearest_index});

`include "nearest_point_search_2d_assert.svh"

    `NPS_ASSERT_IMPL(a_out_no_overwrite, cmd.out_load, !m_axis_tvalid || m_axis_tready,
                     "result overwrote a pending beat")
    `NPS_ASSERT_IMPL(a_start_pipe_idle, cmd.start, !stat.busy,
                     "item accepted with scan pipeline busy")
    `NPS_ASSERT_NEXT(a_issue_fills_pipe, cmd.issue, stat.busy,
                     "table read did not enter the pipeline")
    `NPS_ASSERT_IMPL(a_issue_not_empty, cmd.issue, !stat.empty,
                     "scan issued on an empty table")

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives clear, load and query beats into the nearest point search and
// checks every result beat against an in-bench predictor of the point table,
// under several patterns of input gaps and output back-pressure.
// ----------------------------------------------------------------------------
module testbench;

    import nps_pkg::*;

    localparam int MAX_POINTS   = MAX_REFS_DEF;
    localparam int COORD_W      = COORD_BITS_DEF;
    localparam int IDX_W        = $clog2(MAX_POINTS);
    localparam int DIST_W       = 2 * COORD_W + 1;
    localparam int IN_W         = ((2 * COORD_W + 7) / 8) * 8;
    localparam int OUT_W        = ((IDX_W + DIST_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = MAX_POINTS + 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int SHOW_LIMIT   = 10;

    // Any opcode with the high bit set runs a query.
    localparam logic [OP_W-1:0] OP_QUERY    = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY_HI = 2'd3;

    localparam logic signed [COORD_W-1:0] C_MIN  = 16'sh8000;
    localparam logic signed [COORD_W-1:0] C_MAX  = 16'sh7FFF;
    localparam logic signed [COORD_W-1:0] C_ZERO = 16'sh0000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    index;
        logic [DIST_W-1:0]   sq_dist;
    } answer_t;

    // Mirror of the point table; queues the answer of every accepted beat.
    class nearest_answers;
        logic signed [COORD_W-1:0] pts_x [MAX_POINTS];
        logic signed [COORD_W-1:0] pts_y [MAX_POINTS];
        int unsigned fill;
        answer_t     answers_due [$];
        int unsigned errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function int pending();
            return answers_due.size();
        endfunction

        function void note_accepted(logic [OP_W-1:0] op, logic signed [COORD_W-1:0] x,
                                    logic signed [COORD_W-1:0] y);
            answer_t         a;
            longint          dx;
            longint          dy;
            longint unsigned d;
            longint unsigned best;
            int unsigned     i;
            a    = '0;
            best = 0;
            if (op == OP_CLEAR)
            begin
                fill     = 0;
                a.status = ST_CLEARED;
            end
            else if (op == OP_LOAD)
            begin
                if (fill >= MAX_POINTS)
                    a.status = ST_DROPPED;
                else
                begin
                    pts_x[fill] = x;
                    pts_y[fill] = y;
                    a.index     = IDX_W'(fill);
                    a.status    = ST_STORED;
                    fill++;
                end
            end
            else if (fill == 0)
                a.status = ST_EMPTY;
            else
            begin
                a.status = ST_ANSWERED;
                for (i = 0; i < fill; i++)
                begin
                    dx = longint'(x) - longint'(pts_x[i]);
                    dy = longint'(y) - longint'(pts_y[i]);
                    d  = longint'(dx * dx + dy * dy);
                    // strict compare: the lowest index keeps a tie
                    if (i == 0 || d < best)
                    begin
                        best    = d;
                        a.index = IDX_W'(i);
                    end
                end
                a.sq_dist = best[DIST_W-1:0];
            end
            answers_due = {answers_due, a};
        endfunction

        function void check_beat(answer_t got);
            answer_t want;
            if (answers_due.size() == 0)
            begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("unexpected result beat: status %0d index %0d dist %0d",
                             got.status, got.index, got.sq_dist);
                return;
            end
            want = answers_due.pop_front();
            if (got.status !== want.status || got.index !== want.index ||
                got.sq_dist !== want.sq_dist)
            begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("mismatch: status %0d/%0d index %0d/%0d dist %0d/%0d (want/got)",
                             want.status, got.status, want.index, got.index,
                             want.sq_dist, got.sq_dist);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata;   // point_x, point_y
    logic [OP_W-1:0]     s_axis_tuser;   // opcode
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_W-1:0]    m_axis_tdata;   // nearest_index, distance_sq
    logic [STATUS_W-1:0] m_axis_tuser;   // status

    nearest_answers book;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             hold_req;
    int             sent_items;
    int             cycle_count;

    nearest_point_search_2d #(
        .MAX_REFS   (MAX_POINTS),
        .COORD_BITS (COORD_W)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [COORD_W-1:0] rand_coord();
        return COORD_W'($urandom);
    endfunction

    // 0: anywhere, 1: around base, 2: extremes, zero and base
    function automatic logic signed [COORD_W-1:0] pick_coord(int mode,
                                                             logic signed [COORD_W-1:0] base);
        logic signed [COORD_W-1:0] v;
        case (mode)
            0: v = rand_coord();
            1: v = base + COORD_W'($urandom_range(255)) - 16'sd128;
            default:
                case ($urandom_range(3))
                    0: v = C_MIN;
                    1: v = C_MAX;
                    2: v = C_ZERO;
                    default: v = base;
                endcase
        endcase
        return v;
    endfunction

    task automatic offer_beat(input logic [OP_W-1:0] op, input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({y, x});
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        book.note_accepted(op, x, y);
        sent_items++;
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int n);
        int                        target;
        int                        k;
        int                        q;
        int                        i;
        int                        mode;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] lx;
        logic signed [COORD_W-1:0] ly;
        logic [OP_W-1:0]           qop;
        target = sent_items + n;
        lx     = C_ZERO;
        ly     = C_ZERO;
        while (sent_items < target)
        begin
            if ($urandom_range(99) < 80)
            begin
                // clear, fill a fresh table, then ask about it
                offer_beat(OP_CLEAR, rand_coord(), rand_coord());
                k    = ($urandom_range(9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 8);
                mode = $urandom_range(2);
                cx   = rand_coord();
                cy   = rand_coord();
                for (i = 0; i < k; i++)
                begin
                    if (i == 0 || $urandom_range(7) != 0)
                    begin
                        lx = pick_coord(mode, cx);
                        ly = pick_coord(mode, cy);
                    end
                    offer_beat(OP_LOAD, lx, ly);
                end
                q = $urandom_range(1, 5);
                for (i = 0; i < q; i++)
                begin
                    qop = ($urandom_range(3) == 0) ? OP_QUERY_HI : OP_QUERY;
                    case ($urandom_range(2))
                        0: offer_beat(qop, lx, ly);
                        1: offer_beat(qop, pick_coord(1, cx), pick_coord(1, cy));
                        default: offer_beat(qop, rand_coord(), rand_coord());
                    endcase
                end
            end
            else
                offer_beat(OP_W'($urandom_range(3)), rand_coord(), rand_coord());
        end
    endtask

    // Result side: check accepted beats, then pick the next tready.
    initial
    begin
        answer_t got;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got.status  = m_axis_tuser;
                got.index   = m_axis_tdata[IDX_W-1:0];
                got.sq_dist = m_axis_tdata[IDX_W+DIST_W-1:IDX_W];
                book.check_beat(got);
            end
            if (!rst_n)
                m_axis_tready <= 1'b0;
            else if (hold_req > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_req--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        book           = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 0;
        sent_items     = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_CLEAR;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, ties, opcode three, one-point table
        offer_beat(OP_QUERY, C_ZERO, C_ZERO);
        offer_beat(OP_QUERY_HI, C_MAX, C_MIN);
        offer_beat(OP_LOAD, C_MIN, C_MIN);
        offer_beat(OP_LOAD, C_MAX, C_MAX);
        offer_beat(OP_LOAD, C_MAX, C_MIN);
        offer_beat(OP_LOAD, C_MIN, C_MAX);
        offer_beat(OP_QUERY, C_MAX, C_MAX);
        offer_beat(OP_QUERY, C_MIN, C_MIN);
        offer_beat(OP_QUERY, C_ZERO, C_ZERO);
        offer_beat(OP_LOAD, 16'sh0100, -16'sh0100);
        offer_beat(OP_LOAD, 16'sh0100, -16'sh0100);
        offer_beat(OP_QUERY, 16'sh0100, -16'sh0100);
        offer_beat(OP_QUERY_HI, 16'sh0180, C_ZERO);
        offer_beat(OP_CLEAR, C_MAX, C_MAX);
        offer_beat(OP_QUERY, C_ZERO, C_ZERO);
        offer_beat(OP_LOAD, C_MAX, C_MIN);
        offer_beat(OP_QUERY, C_MIN, C_MAX);
        offer_beat(OP_LOAD, -16'sh0001, 16'sh0001);
        offer_beat(OP_LOAD, 16'sh0001, -16'sh0001);
        offer_beat(OP_QUERY_HI, C_ZERO, C_ZERO);
        offer_beat(OP_CLEAR, C_ZERO, C_ZERO);
        wait_results_drained();

        // no gaps; the output stalls long enough to back up the input
        hold_req = HOLD_CYCLES;
        run_random(135);
        wait_results_drained();

        send_idle_pct  = 61;
        recv_stall_pct = 0;
        run_random(135);
        wait_results_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 61;
        run_random(135);
        wait_results_drained();

        send_idle_pct  = 36;
        recv_stall_pct = 36;
        run_random(135);
        wait_results_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (book.errors == 0 && book.pending() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
